// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define BQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset.
`define BQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== sv/bq_pkg.sv =====
// Package with widths, codes and shared types of the biquad wet/dry filter.
package bq_pkg;

    // Field and coefficient widths.
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 24;

    // Product and accumulator widths; five products need three guard bits.
    localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS  = PROD_BITS + 3;
    localparam int SHR_BITS  = ACC_BITS - COEF_FRAC_BITS;

    // Configuration register file.
    localparam int NUM_REGS     = 7;
    localparam int CFG_IDX_BITS = $clog2(NUM_REGS);

    // Rounding constant and saturation limits.
    localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
        ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SHR_BITS-1:0] SAT_MAX_W =
        (SHR_BITS'(1) << (SAMPLE_BITS - 1)) - SHR_BITS'(1);
    localparam logic signed [SHR_BITS-1:0] SAT_MIN_W = ~SAT_MAX_W;
    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Reset value 1.0 of the unity gains.
    localparam logic signed [COEF_BITS-1:0] COEF_ONE =
        COEF_BITS'(1) << COEF_FRAC_BITS;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FF0 = 3'd0,
        REG_FF1 = 3'd1,
        REG_FF2 = 3'd2,
        REG_FB1 = 3'd3,
        REG_FB2 = 3'd4,
        REG_WET = 3'd5,
        REG_DRY = 3'd6
    } t_reg_idx;

    // Product terms fed to the shared multiplier, in issue order.
    typedef enum logic [2:0] {
        T_FF0 = 3'd0,
        T_FF1 = 3'd1,
        T_FF2 = 3'd2,
        T_FB1 = 3'd3,
        T_FB2 = 3'd4,
        T_DRY = 3'd5,
        T_WET = 3'd6
    } t_term;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FILT,
        S_FWAIT,
        S_YLAT,
        S_MIX,
        S_MWAIT,
        S_DONE
    } t_state;

    // Coefficient set.
    typedef struct packed {
        logic signed [COEF_BITS-1:0] ff0;
        logic signed [COEF_BITS-1:0] ff1;
        logic signed [COEF_BITS-1:0] ff2;
        logic signed [COEF_BITS-1:0] fb1;
        logic signed [COEF_BITS-1:0] fb2;
        logic signed [COEF_BITS-1:0] wet;
        logic signed [COEF_BITS-1:0] dry;
    } t_coefs;

    // Commands to the multiply-accumulate unit.
    typedef struct packed {
        logic issue;
        logic first;
        logic neg;
    } t_mac_op;

    // Sequencer control word.
    typedef struct packed {
        t_mac_op mac;
        t_term   term;
        logic    load_y;
        logic    load_out;
    } t_ctl;

endpackage

// ===== sv/bq_regs.sv =====
// Configuration register file holding the filter and mix coefficients.
module bq_regs import bq_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [COEF_BITS-1:0]    i_cfg_data,
    output t_coefs                  o_coefs
);

    t_coefs r_coefs;
    t_coefs n_coefs;

    // Decode the index; unused codes leave every register alone.
    always_comb begin
        n_coefs = r_coefs;
        if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_FF0: n_coefs.ff0 = i_cfg_data;
                REG_FF1: n_coefs.ff1 = i_cfg_data;
                REG_FF2: n_coefs.ff2 = i_cfg_data;
                REG_FB1: n_coefs.fb1 = i_cfg_data;
                REG_FB2: n_coefs.fb2 = i_cfg_data;
                REG_WET: n_coefs.wet = i_cfg_data;
                REG_DRY: n_coefs.dry = i_cfg_data;
                default: n_coefs = r_coefs;
            endcase
        end
    end

    // Reset to a straight wire: unity feedforward and unity wet gain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.ff0 <= COEF_ONE;
            r_coefs.ff1 <= '0;
            r_coefs.ff2 <= '0;
            r_coefs.fb1 <= '0;
            r_coefs.fb2 <= '0;
            r_coefs.wet <= COEF_ONE;
            r_coefs.dry <= '0;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    assign o_coefs = r_coefs;

endmodule

// ===== sv/bq_mac.sv =====
// Shared multiply-accumulate unit with rounding and saturation of the sum.
module bq_mac import bq_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mac_op                       i_op,
    input  logic signed [COEF_BITS-1:0]   i_coef,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic [SAMPLE_BITS-1:0]        o_sat
);

    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [PROD_BITS-1:0] n_prod;
    logic                        r_pvld;
    logic                        r_first;
    logic                        r_neg;
    logic signed [ACC_BITS-1:0]  r_acc;
    logic signed [ACC_BITS-1:0]  n_acc;
    logic signed [ACC_BITS-1:0]  prod_ext;
    logic signed [ACC_BITS-1:0]  acc_base;
    logic signed [ACC_BITS-1:0]  rnd;
    logic signed [SHR_BITS-1:0]  shr;

    // First stage: one signed product.
    assign n_prod = i_coef * i_sample;

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_first <= i_op.first;
        r_neg   <= i_op.neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_op.issue;
        end
    end

    // Second stage: add or subtract the product, restarting on the first term.
    always_comb begin
        prod_ext = ACC_BITS'(r_prod);
        acc_base = r_first ? '0 : r_acc;
        n_acc    = r_neg ? acc_base - prod_ext : acc_base + prod_ext;
    end

    always_ff @(posedge i_clk) begin
        if (r_pvld) begin
            r_acc <= n_acc;
        end
    end

    // Round half up, drop the fraction and clamp to the sample range.
    always_comb begin
        rnd = r_acc + ROUND_HALF;
        shr = rnd[ACC_BITS-1:COEF_FRAC_BITS];
        if (shr > SAT_MAX_W) begin
            o_sat = SAT_MAX;
        end else if (shr < SAT_MIN_W) begin
            o_sat = SAT_MIN;
        end else begin
            o_sat = shr[SAMPLE_BITS-1:0];
        end
    end

endmodule

// ===== sv/bq_seq.sv =====
// Sequencer that issues the seven products of one sample to the shared unit.
module bq_seq import bq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_out_free,
    output logic o_idle,
    output t_ctl o_ctl
);

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;

    // Next state and term counter.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    n_state = S_FILT;
                end
            end
            S_FILT: begin
                n_cnt = r_cnt + 3'd1;
                if (t_term'(r_cnt) == T_FB2) begin
                    n_state = S_FWAIT;
                end
            end
            S_FWAIT: n_state = S_YLAT;
            S_YLAT:  n_state = S_MIX;
            S_MIX:   n_state = S_MWAIT;
            S_MWAIT: n_state = S_DONE;
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Control outputs per state.
    always_comb begin
        o_ctl  = '0;
        o_idle = 1'b0;
        case (r_state)
            S_IDLE: o_idle = 1'b1;
            S_FILT: begin
                o_ctl.term      = t_term'(r_cnt);
                o_ctl.mac.issue = 1'b1;
                o_ctl.mac.first = (t_term'(r_cnt) == T_FF0);
                o_ctl.mac.neg   = (t_term'(r_cnt) == T_FB1) ||
                                  (t_term'(r_cnt) == T_FB2);
            end
            S_YLAT: begin
                o_ctl.load_y    = 1'b1;
                o_ctl.term      = T_DRY;
                o_ctl.mac.issue = 1'b1;
                o_ctl.mac.first = 1'b1;
            end
            S_MIX: begin
                o_ctl.term      = T_WET;
                o_ctl.mac.issue = 1'b1;
            end
            S_DONE: o_ctl.load_out = i_out_free;
            default: o_ctl = '0;
        endcase
    end

endmodule

// ===== sv/biquad_iir_wet_dry.sv =====
// Direct form I biquad with wet/dry mix. One signed multiplier serves all seven
// products of a sample under a small sequencer. Once a word is accepted, the
// sequencer issues the five filter products in turn, waits for the last
// product to reach the accumulator, latches the filter output and issues the
// dry product, issues the wet product, waits for that product to reach the
// accumulator and loads the output register. It then returns to idle, and only
// there takes the next word, so no word is taken while one is in progress.
// The result may still wait at the output while the next word is taken; a
// result still stalled there when the next one is ready holds the load, and so
// the next input, until it is taken. Coefficients are Q8.24.
module biquad_iir_wet_dry import bq_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [SAMPLE_BITS-1:0]  i_sample_in,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [SAMPLE_BITS-1:0]  o_sample_out,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [COEF_BITS-1:0]    i_cfg_data
);

    t_coefs                  coefs;
    t_ctl                    ctl;
    logic                    idle;
    logic                    accept;
    logic                    out_free;
    logic [SAMPLE_BITS-1:0]  sat;
    logic signed [COEF_BITS-1:0]   op_coef;
    logic signed [SAMPLE_BITS-1:0] op_sample;

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [SAMPLE_BITS-1:0] r_xd1;
    logic signed [SAMPLE_BITS-1:0] r_xd2;
    logic signed [SAMPLE_BITS-1:0] r_yd1;
    logic signed [SAMPLE_BITS-1:0] r_yd2;
    logic [SAMPLE_BITS-1:0]        r_out;
    logic                          r_out_valid;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = !idle;
    assign accept      = i_valid && idle;
    assign out_free    = !r_out_valid || !i_stall;

    bq_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coefs     (coefs)
    );

    bq_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_out_free (out_free),
        .o_idle     (idle),
        .o_ctl      (ctl)
    );

    // Operand selection for the term being issued.
    always_comb begin
        case (ctl.term)
            T_FF0:   begin op_coef = coefs.ff0; op_sample = r_x;   end
            T_FF1:   begin op_coef = coefs.ff1; op_sample = r_xd1; end
            T_FF2:   begin op_coef = coefs.ff2; op_sample = r_xd2; end
            T_FB1:   begin op_coef = coefs.fb1; op_sample = r_yd1; end
            T_FB2:   begin op_coef = coefs.fb2; op_sample = r_yd2; end
            T_DRY:   begin op_coef = coefs.dry; op_sample = r_x;   end
            T_WET:   begin op_coef = coefs.wet; op_sample = r_yd1; end
            default: begin op_coef = '0;        op_sample = '0;    end
        endcase
    end

    bq_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (ctl.mac),
        .i_coef   (op_coef),
        .i_sample (op_sample),
        .o_sat    (sat)
    );

    // Current input word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= i_sample_in;
        end
    end

    // Delay line shifts once the filter output is known.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xd1 <= '0;
            r_xd2 <= '0;
            r_yd1 <= '0;
            r_yd2 <= '0;
        end else if (ctl.load_y) begin
            r_xd2 <= r_xd1;
            r_xd1 <= r_x;
            r_yd2 <= r_yd1;
            r_yd1 <= sat;
        end
    end

    // Output register holds the mixed word until it is taken.
    always_ff @(posedge i_clk) begin
        if (ctl.load_out) begin
            r_out <= sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out;

endmodule

// ===== sv/bq_chk.sv =====
// Port-level checker for the biquad wet/dry filter, bound to the top level.
`include "assert_macros.svh"

module bq_chk import bq_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [SAMPLE_BITS-1:0] o_sample_out
);

    logic in_take;
    logic out_wait;

    // An input word is taken, or a result word waits at the output.
    assign in_take  = i_valid && !o_stall;
    assign out_wait = o_valid && i_stall;

    // Reset empties the output register.
    `BQ_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

    // An accepted word keeps the block busy in the following cycle.
    `BQ_ASSERT(a_busy, i_clk, i_rst_n, in_take |=> o_stall, "input taken twice")

    // A new result only appears at the end of a busy period.
    `BQ_ASSERT(a_out_src, i_clk, i_rst_n, $rose(o_valid) |-> $past(o_stall), "stray result")

    // A stalled result stays put.
    `BQ_ASSERT(a_hold_v, i_clk, i_rst_n, out_wait |=> o_valid, "stalled result dropped")
    `BQ_ASSERT(a_hold_d, i_clk, i_rst_n, out_wait |=> $stable(o_sample_out), "word changed")

endmodule

bind biquad_iir_wet_dry bq_chk u_chk (.*);
